@@ hdl/lkl_pkg.sv @@
// shared types, constants and helper functions for the lane keeping steering law
`timescale 1ns / 1ps
package lkl_pkg;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_DIST_GAIN       = 3'd0;
  localparam cfg_index_t CFG_ANGLE_GAIN_HIGH = 3'd1;
  localparam cfg_index_t CFG_ANGLE_GAIN_LOW  = 3'd2;
  localparam cfg_index_t CFG_BRAKE_GAIN      = 3'd3;
  localparam cfg_index_t CFG_TOP_SPEED       = 3'd4;
  localparam cfg_index_t CFG_CURVE_SPEED     = 3'd5;
  localparam cfg_index_t CFG_TARGET_OFFSET   = 3'd6;

  typedef struct packed {
    logic signed [15:0] dist_gain;
    logic signed [15:0] angle_gain_high;
    logic signed [15:0] angle_gain_low;
    logic signed [15:0] brake_gain;
    logic [14:0]        top_speed;
    logic [14:0]        curve_speed;
    logic [9:0]         target_offset;
  } cfg_t;

  localparam int CordicIters = 17;
  localparam int SqrtSteps   = 32;
  localparam int DivSteps    = 32;

  localparam logic signed [18:0] HALF_PI_Q13 = 19'sd12868;
  localparam logic [31:0]        DIST_Q_MAX  = 32'h8003FFFE;
  localparam logic signed [16:0] SPEED_LO    = 17'sd700;
  localparam logic signed [16:0] SPEED_HI    = 17'sd1500;
  // ceil(2^26 / 25), exact floor division by 25 for values below 2^21
  localparam logic [21:0]        DIV25_MUL   = 22'd2684355;
  localparam logic signed [54:0] STEER_BASE  = 55'sd209715200;

  function automatic logic [16:0] atan_q16(input int i);
    logic [16:0] v;
    case (i)
      0:  v = 17'd51472;
      1:  v = 17'd30386;
      2:  v = 17'd16055;
      3:  v = 17'd8150;
      4:  v = 17'd4091;
      5:  v = 17'd2047;
      6:  v = 17'd1024;
      7:  v = 17'd512;
      8:  v = 17'd256;
      9:  v = 17'd128;
      10: v = 17'd64;
      11: v = 17'd32;
      12: v = 17'd16;
      13: v = 17'd8;
      14: v = 17'd4;
      15: v = 17'd2;
      16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // truncate a q.21 value toward zero and saturate to int16
  function automatic logic signed [15:0] trunc_sat21(input logic signed [54:0] v);
    logic signed [54:0] adj;
    logic signed [33:0] sh;
    adj = v + (v[54] ? 55'sd2097151 : 55'sd0);
    sh  = 34'(adj >>> 21);
    if (sh > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (sh < -34'sd32768) begin
      return 16'sh8000;
    end else begin
      return 16'(sh);
    end
  endfunction

endpackage

@@ hdl/lkl_line_if.sv @@
// input channel carrying one lane line
`timescale 1ns / 1ps
interface lkl_line_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] line_a;
  logic signed [31:0] line_b;
  logic signed [31:0] line_c;
  modport source (output valid, line_a, line_b, line_c, input ready);
  modport sink (input valid, line_a, line_b, line_c, output ready);
endinterface

@@ hdl/lkl_cmd_if.sv @@
// output channel carrying speed and steering commands
`timescale 1ns / 1ps
interface lkl_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_cmd;
  logic signed [15:0] steer_cmd;
  modport source (output valid, speed_cmd, steer_cmd, input ready);
  modport sink (input valid, speed_cmd, steer_cmd, output ready);
endinterface

@@ hdl/lkl_cfg_if.sv @@
// register write channel
`timescale 1ns / 1ps
interface lkl_cfg_if;
  logic                    valid;
  logic                    ready;
  lkl_pkg::cfg_index_t     index;
  logic [15:0]             data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/lkl_cordic.sv @@
// pipelined cordic vectoring unit giving the heading angle in q2.13
`timescale 1ns / 1ps
module lkl_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [14:0] angle
);

  localparam int N = lkl_pkg::CordicIters;

  logic signed [34:0] x [0:N];
  logic signed [34:0] y [0:N];
  logic signed [18:0] z [0:N];
  // b zero, a zero, b positive
  logic [2:0]         flg [0:N];

  logic signed [34:0] a_ext;
  logic signed [34:0] b_ext;
  logic signed [18:0] zr;

  always_comb begin
    a_ext = 35'(a);
    b_ext = 35'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= a[31] ? -a_ext : a_ext;
      y[0]   <= a[31] ? -b_ext : b_ext;
      z[0]   <= '0;
      flg[0] <= {b == 32'sd0, a == 32'sd0, b > 32'sd0};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y[i][34]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed({2'b00, lkl_pkg::atan_q16(i)});
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed({2'b00, lkl_pkg::atan_q16(i)});
        end
        flg[i+1] <= flg[i];
      end
    end
  end

  // round q.16 to q2.13 with a floor shift
  always_comb zr = (z[N] + 19'sd4) >>> 3;

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg[N][2]) begin
        angle <= '0;
      end else if (flg[N][1]) begin
        angle <= flg[N][0] ? 15'(lkl_pkg::HALF_PI_Q13) : 15'(-lkl_pkg::HALF_PI_Q13);
      end else if (zr > lkl_pkg::HALF_PI_Q13) begin
        angle <= 15'(lkl_pkg::HALF_PI_Q13);
      end else if (zr < -lkl_pkg::HALF_PI_Q13) begin
        angle <= 15'(-lkl_pkg::HALF_PI_Q13);
      end else begin
        angle <= 15'(zr);
      end
    end
  end

endmodule

@@ hdl/lkl_dist.sv @@
// distance error pipeline: norm by digit square root, then restoring divider
`timescale 1ns / 1ps
module lkl_dist (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  input  logic [9:0]         target_offset,
  output logic               out_valid,
  output logic signed [31:0] dist_err
);

  localparam int NS = lkl_pkg::SqrtSteps;
  localparam int ND = lkl_pkg::DivSteps;

  // front: squares and line value
  logic signed [63:0] pa, pb;
  logic signed [40:0] n41;
  logic [62:0]        sqa, sqb;
  logic signed [40:0] num;
  logic               v0;

  always_comb begin
    pa  = 64'(a) * 64'(a);
    pb  = 64'(b) * 64'(b);
    n41 = 41'(a) * 41'sd160 + 41'(b) * 41'sd190 + 41'(c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa <= pa[62:0];
      sqb <= pb[62:0];
      num <= n41;
    end
  end

  // square root pipeline, two radicand bits per stage
  logic [63:0] rad  [0:NS];
  logic [33:0] rem  [0:NS];
  logic [31:0] root [0:NS];
  logic [39:0] absn [0:NS];
  logic        vs   [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      rad[0]  <= {1'b0, sqa} + {1'b0, sqb};
      rem[0]  <= '0;
      root[0] <= '0;
      absn[0] <= num[40] ? 40'(-num) : num[39:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;
    always_comb begin
      t     = {rem[k], rad[k][63:62]};
      trial = {2'b00, root[k], 2'b01};
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? 34'(t - trial) : t[33:0];
        root[k+1] <= {root[k][30:0], ge};
        rad[k+1]  <= {rad[k][61:0], 2'b00};
        absn[k+1] <= absn[k];
      end
    end
  end

  // divider: quotient saturates when the high part already reaches the divisor
  logic [31:0] rr_in;
  logic [31:0] rmd [0:ND];
  logic [31:0] dd  [0:ND];
  logic [31:0] q   [0:ND];
  logic [31:0] rr  [0:ND];
  logic        sat [0:ND];
  logic        vd  [0:ND];

  always_comb rr_in = (root[NS] == 32'd0) ? 32'd1 : root[NS];

  always_ff @(posedge clk) begin
    if (en) begin
      rmd[0] <= {16'd0, absn[NS][39:24]};
      dd[0]  <= {absn[NS][23:0], 8'd0};
      q[0]   <= '0;
      rr[0]  <= rr_in;
      sat[0] <= {16'd0, absn[NS][39:24]} >= rr_in;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [32:0] t;
    logic        ge;
    always_comb begin
      t  = {rmd[j], dd[j][31]};
      ge = t >= {1'b0, rr[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rmd[j+1] <= ge ? 32'(t - {1'b0, rr[j]}) : t[31:0];
        q[j+1]   <= {q[j][30:0], ge};
        dd[j+1]  <= {dd[j][30:0], 1'b0};
        rr[j+1]  <= rr[j];
        sat[j+1] <= sat[j];
      end
    end
  end

  // valid bits run beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= NS; i++) vs[i] <= 1'b0;
      for (int i = 0; i <= ND; i++) vd[i] <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      vs[0] <= v0;
      for (int i = 1; i <= NS; i++) vs[i] <= vs[i-1];
      vd[0] <= vs[NS];
      for (int i = 1; i <= ND; i++) vd[i] <= vd[i-1];
      out_valid <= vd[ND];
    end
  end

  logic [31:0]        qf;
  logic signed [32:0] d33;

  always_comb begin
    qf  = (sat[ND] || q[ND] > lkl_pkg::DIST_Q_MAX) ? lkl_pkg::DIST_Q_MAX : q[ND];
    d33 = $signed({1'b0, qf}) - $signed({15'd0, target_offset, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_err <= (d33 > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF : d33[31:0];
    end
  end

endmodule

@@ hdl/lane_keeping_steering_law_top.sv @@
// top level: steering law pipeline with register port and output skid stage
`timescale 1ns / 1ps
// Takes one lane line a*x+b*y+c=0 (Q16.16) per cycle and returns a speed and a
// steering command, both saturated int16; a line with a and b both zero is taken
// and gives no word. Throughput is one line per clock while the skid register is
// empty; the distance path is the 32-stage square root of a*a+b*b followed by the
// 32-stage restoring divider, and the heading cordic (17 stages) runs beside them.
// A finished word waits in the output register while one more word can land in a
// skid register; line_in.ready drops only while the skid register is full.
// The user must write registers through cfg only while the block is idle; the block itself does not enforce this.
module lane_keeping_steering_law_top (
  input  logic         clk,
  input  logic         rst,
  lkl_line_if.sink     line_in,
  lkl_cmd_if.source    cmd_out,
  lkl_cfg_if.sink      cfg
);

  localparam int AngDelay = 49;

  lkl_pkg::cfg_t cfg_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.dist_gain       <= 16'sd128;
      cfg_r.angle_gain_high <= 16'sd7680;
      cfg_r.angle_gain_low  <= 16'sd3072;
      cfg_r.brake_gain      <= 16'sd256;
      cfg_r.top_speed       <= 15'd800;
      cfg_r.curve_speed     <= 15'd400;
      cfg_r.target_offset   <= 10'd90;
    end else if (cfg.valid) begin
      case (cfg.index)
        lkl_pkg::CFG_DIST_GAIN:       cfg_r.dist_gain       <= cfg.data;
        lkl_pkg::CFG_ANGLE_GAIN_HIGH: cfg_r.angle_gain_high <= cfg.data;
        lkl_pkg::CFG_ANGLE_GAIN_LOW:  cfg_r.angle_gain_low  <= cfg.data;
        lkl_pkg::CFG_BRAKE_GAIN:      cfg_r.brake_gain      <= cfg.data;
        lkl_pkg::CFG_TOP_SPEED:       cfg_r.top_speed       <= cfg.data[14:0];
        lkl_pkg::CFG_CURVE_SPEED:     cfg_r.curve_speed     <= cfg.data[14:0];
        lkl_pkg::CFG_TARGET_OFFSET:   cfg_r.target_offset   <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid register holds a word
  logic en;
  logic skid_v;
  logic out_v;
  logic in_fire;
  logic in_ok;

  assign en            = !skid_v;
  assign line_in.ready = en;
  assign in_fire       = line_in.valid && line_in.ready;
  assign in_ok         = in_fire && !(line_in.line_a == 32'sd0 && line_in.line_b == 32'sd0);

  logic signed [14:0] angle;
  logic               dist_v;
  logic signed [31:0] dist_err;

  lkl_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .a     (line_in.line_a),
    .b     (line_in.line_b),
    .angle (angle)
  );

  lkl_dist u_dist (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_ok),
    .a             (line_in.line_a),
    .b             (line_in.line_b),
    .c             (line_in.line_c),
    .target_offset (cfg_r.target_offset),
    .out_valid     (dist_v),
    .dist_err      (dist_err)
  );

  // line the angle up with the distance result
  logic signed [14:0] ang_d [0:AngDelay-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ang_d[0] <= angle;
      for (int i = 1; i < AngDelay; i++) ang_d[i] <= ang_d[i-1];
    end
  end

  // tail: speed, gain schedule, steering
  logic               tv [1:8];
  logic signed [30:0] bp1;
  logic signed [15:0] dsp1;
  logic signed [47:0] dk1, dk2, dk3, dk4, dk5, dk6, dk7;
  logic signed [14:0] ang1, ang2, ang3, ang4, ang5, ang6;
  logic signed [46:0] p2;
  logic signed [47:0] s21;
  logic signed [15:0] speed3, speed4, speed5, speed6, speed7, speed8;
  logic signed [16:0] m3, md3, hd3;
  logic               lt4, gt4, lt5, gt5, neg5;
  logic signed [27:0] mp4;
  logic [26:0]        u4;
  logic [42:0]        qm5;
  logic signed [17:0] sq5;
  logic signed [17:0] kq18;
  logic signed [16:0] kq6;
  logic signed [31:0] kp7;
  logic signed [54:0] st7;
  logic signed [15:0] steer8;
  logic signed [14:0] ang0;

  always_comb begin
    ang0 = ang_d[AngDelay-1];
    s21  = 48'(p2) - $signed({12'd0, cfg_r.top_speed, 21'd0});
    m3   = -17'(speed3);
    md3  = m3 - lkl_pkg::SPEED_LO;
    hd3  = 17'(cfg_r.angle_gain_high) - 17'(cfg_r.angle_gain_low);
    u4   = mp4[27] ? 27'(-mp4) : mp4[26:0];
    sq5  = neg5 ? -$signed({1'b0, qm5[42:26]}) : $signed({1'b0, qm5[42:26]});
    kq18 = 18'(cfg_r.angle_gain_high) - sq5;
    st7  = lkl_pkg::STEER_BASE + (55'(dk7) <<< 5) + 55'(kp7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // speed product terms
      bp1     <= 31'(cfg_r.brake_gain * $signed({2'b00, ang0[14] ? 14'(-ang0) : ang0[13:0]}));
      dsp1    <= $signed({1'b0, cfg_r.top_speed}) - $signed({1'b0, cfg_r.curve_speed});
      dk1     <= 48'(cfg_r.dist_gain) * 48'(dist_err);
      ang1    <= ang0;
      // brake times speed span
      p2      <= 47'(bp1) * 47'(dsp1);
      dk2     <= dk1;
      ang2    <= ang1;
      // speed command
      speed3  <= lkl_pkg::trunc_sat21(55'(s21));
      dk3     <= dk2;
      ang3    <= ang2;
      // gain interpolation product
      lt4     <= m3 < lkl_pkg::SPEED_LO;
      gt4     <= m3 > lkl_pkg::SPEED_HI;
      mp4     <= $signed({1'b0, md3[9:0]}) * 28'(hd3);
      speed4  <= speed3;
      dk4     <= dk3;
      ang4    <= ang3;
      // divide by 800 as shift by 5 and reciprocal of 25
      qm5     <= 43'(u4[26:5]) * 43'(lkl_pkg::DIV25_MUL);
      neg5    <= mp4[27];
      lt5     <= lt4;
      gt5     <= gt4;
      speed5  <= speed4;
      dk5     <= dk4;
      ang5    <= ang4;
      // angle gain
      kq6     <= lt5 ? 17'(cfg_r.angle_gain_high) :
                 gt5 ? 17'(cfg_r.angle_gain_low) : 17'(kq18);
      speed6  <= speed5;
      dk6     <= dk5;
      ang6    <= ang5;
      // gain times angle
      kp7     <= 32'(kq6) * 32'(ang6);
      speed7  <= speed6;
      dk7     <= dk6;
      // steering command
      steer8  <= lkl_pkg::trunc_sat21(st7);
      speed8  <= speed7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 8; i++) tv[i] <= 1'b0;
    end else if (en) begin
      tv[1] <= dist_v;
      for (int i = 2; i <= 8; i++) tv[i] <= tv[i-1];
    end
  end

  // output register plus skid word
  logic signed [15:0] out_speed, out_steer, skid_speed, skid_steer;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (cmd_out.ready) begin
        skid_v <= 1'b0;
      end
    end else if (tv[8]) begin
      if (out_v && !cmd_out.ready) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (cmd_out.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (cmd_out.ready) begin
        out_speed <= skid_speed;
        out_steer <= skid_steer;
      end
    end else if (tv[8]) begin
      if (out_v && !cmd_out.ready) begin
        skid_speed <= speed8;
        skid_steer <= steer8;
      end else begin
        out_speed <= speed8;
        out_steer <= steer8;
      end
    end
  end

  assign cmd_out.valid     = out_v;
  assign cmd_out.speed_cmd = out_speed;
  assign cmd_out.steer_cmd = out_steer;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid word held without an output word");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> !line_in.ready)
    else $error("input taken while skid word pending");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (tv[8] && en && out_v && !cmd_out.ready) |=> skid_v)
    else $error("finished word lost on output stall");

endmodule

@@ tb/tb_top.sv @@
// testbench for the lane keeping steering law: directed and random lines and registers against a predictor
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] steer;
  } cmd_word_t;

  class steer_scoreboard;
    cmd_word_t          pending_cmds[$];
    int                 errors;
    int                 lines_taken;
    int                 cmds_checked;
    int                 degenerate_lines;
    logic signed [15:0] dist_gain;
    logic signed [15:0] gain_high;
    logic signed [15:0] gain_low;
    logic signed [15:0] brake_gain;
    logic [14:0]        top_speed;
    logic [14:0]        curve_speed;
    logic [9:0]         target_offset;
    longint             atan_q16_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                             512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    function new();
      dist_gain = 16'sd128;
      gain_high = 16'sd7680;
      gain_low = 16'sd3072;
      brake_gain = 16'sd256;
      top_speed = 15'd800;
      curve_speed = 15'd400;
      target_offset = 10'd90;
    endfunction

    function void set_reg(lkl_pkg::cfg_index_t idx, logic [15:0] v);
      case (idx)
        lkl_pkg::CFG_DIST_GAIN:       dist_gain = v;
        lkl_pkg::CFG_ANGLE_GAIN_HIGH: gain_high = v;
        lkl_pkg::CFG_ANGLE_GAIN_LOW:  gain_low = v;
        lkl_pkg::CFG_BRAKE_GAIN:      brake_gain = v;
        lkl_pkg::CFG_TOP_SPEED:       top_speed = v[14:0];
        lkl_pkg::CFG_CURVE_SPEED:     curve_speed = v[14:0];
        lkl_pkg::CFG_TARGET_OFFSET:   target_offset = v[9:0];
        default: ;
      endcase
    endfunction

    function longint heading(longint a, longint b);
      longint x, y, z, nx;
      z = 0;
      if (b == 0) return 0;
      if (a == 0) return (b > 0) ? 12868 : -12868;
      x = (a < 0) ? -a : a;
      y = (a < 0) ? -b : b;
      for (int i = 0; i < 17; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_q16_tab[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_q16_tab[i];
        end
        x = nx;
      end
      z = (z + 4) >>> 3;
      if (z > 12868) z = 12868;
      if (z < -12868) z = -12868;
      return z;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint q21_to_int16(longint v);
      longint t;
      t = (v >= 0) ? (v >>> 21) : -((-v) >>> 21);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    function void note_line(logic signed [31:0] la, logic signed [31:0] lb,
                            logic signed [31:0] lc);
      longint a, b, c, ang, absang, num, dist_err, s21, speed, m, k, hi, lo, st21, top, cur;
      longint unsigned r, q;
      cmd_word_t w;
      a = la;
      b = lb;
      c = lc;
      lines_taken++;
      if (a == 0 && b == 0) begin
        degenerate_lines++;
        return;
      end
      ang = heading(a, b);
      absang = (ang < 0) ? -ang : ang;
      num = 160 * a + 190 * b + c;
      if (num < 0) num = -num;
      r = root_floor(longint'(unsigned'(a * a)) + longint'(unsigned'(b * b)));
      if (r == 0) r = 1;
      q = (longint'(unsigned'(num)) * 256) / r;
      if (q > 64'h8003FFFE) q = 64'h8003FFFE;
      dist_err = longint'(q) - longint'(target_offset) * 256;
      if (dist_err > 64'sh7FFFFFFF) dist_err = 64'sh7FFFFFFF;
      top = top_speed;
      cur = curve_speed;
      s21 = -(top * 2097152 - longint'(brake_gain) * absang * (top - cur));
      speed = q21_to_int16(s21);
      hi = gain_high;
      lo = gain_low;
      m = -speed;
      if (m < 700) k = hi;
      else if (m > 1500) k = lo;
      else k = hi - ((m - 700) * (hi - lo)) / 800;
      st21 = 100 * 2097152 + 32 * longint'(dist_gain) * dist_err + k * ang;
      w.speed = speed[15:0];
      w.steer = 16'(q21_to_int16(st21));
      pending_cmds = {pending_cmds, w};
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_cmd(logic signed [15:0] speed, logic signed [15:0] steer);
      cmd_word_t w;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unexpected word speed %0d steer %0d", speed, steer));
        return;
      end
      w = pending_cmds.pop_front();
      cmds_checked++;
      if (speed !== w.speed)
        report($sformatf("speed_cmd %0d, want %0d", speed, w.speed));
      if (steer !== w.steer)
        report($sformatf("steer_cmd %0d, want %0d", steer, w.steer));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_gaps = 1'b0;
  int   idle_cycles = 0;
  steer_scoreboard sb = new();

  lkl_line_if line_ch();
  lkl_cmd_if  cmd_ch();
  lkl_cfg_if  cfg_ch();

  lane_keeping_steering_law_top uut (
    .clk(clk),
    .rst(rst),
    .line_in(line_ch.sink),
    .cmd_out(cmd_ch.source),
    .cfg(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  initial begin
    line_ch.valid = 1'b0;
    line_ch.line_a = '0;
    line_ch.line_b = '0;
    line_ch.line_c = '0;
    cmd_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lkl_pkg::CFG_DIST_GAIN;
    cfg_ch.data = '0;
  end

  // monitors and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (line_ch.valid && line_ch.ready)
        sb.note_line(line_ch.line_a, line_ch.line_b, line_ch.line_c);
      if (cmd_ch.valid && cmd_ch.ready)
        sb.check_cmd(cmd_ch.speed_cmd, cmd_ch.steer_cmd);
      if ((line_ch.valid && line_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("timeout: no progress, %0d words outstanding", sb.pending_cmds.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver with random stalls per word
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_ch.ready <= 1'b1;
      @(posedge clk);
      while (!cmd_ch.valid) @(posedge clk);
    end
  end

  task automatic send_line(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      line_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_ch.valid <= 1'b1;
    line_ch.line_a <= a;
    line_ch.line_b <= b;
    line_ch.line_c <= c;
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    line_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    // degenerate lines may still be in the 77 stage pipe
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(lkl_pkg::cfg_index_t idx, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_regs(logic [15:0] dg, logic [15:0] gh, logic [15:0] gl,
                           logic [15:0] bg, logic [15:0] ts, logic [15:0] cs,
                           logic [15:0] tgt);
    write_reg(lkl_pkg::CFG_DIST_GAIN, dg);
    write_reg(lkl_pkg::CFG_ANGLE_GAIN_HIGH, gh);
    write_reg(lkl_pkg::CFG_ANGLE_GAIN_LOW, gl);
    write_reg(lkl_pkg::CFG_BRAKE_GAIN, bg);
    write_reg(lkl_pkg::CFG_TOP_SPEED, ts);
    write_reg(lkl_pkg::CFG_CURVE_SPEED, cs);
    write_reg(lkl_pkg::CFG_TARGET_OFFSET, tgt);
  endtask

  function automatic logic [31:0] coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'($signed($urandom_range(0, 4096)) - 2048);
      3: return 32'($signed($urandom_range(0, 16)) - 8);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_lines(int n);
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = coef();
      b = coef();
      case ($urandom_range(0, 19))
        0: begin a = '0; b = '0; end
        1: a = '0;
        2: b = '0;
        default: ;
      endcase
      send_line(a, b, ($urandom_range(0, 1) == 1) ? $urandom() : coef());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, axes, degenerate lines under reset registers
    send_line(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_line(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_line(32'h0, 32'h0, 32'h1234_5678);
    send_line(32'h0, 32'h0, 32'h0);
    send_line(32'h0, 32'h0001_0000, 32'hFF40_0000);
    send_line(32'h0, 32'hFFFF_0000, 32'h0);
    send_line(32'h0, 32'h1, 32'h7FFF_FFFF);
    send_line(32'h0001_0000, 32'h0, 32'hFF60_0000);
    send_line(32'hFFFF_0000, 32'h0, 32'h00A0_0000);
    send_line(32'h0001_0000, 32'h0001_0000, 32'h0);
    send_line(32'hFFFF_0000, 32'h0001_0000, 32'h0);
    send_line(32'hFFFF_0000, 32'hFFFF_0000, 32'h0);
    send_line(32'h1, 32'h1, 32'h0);
    send_line(32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
    random_lines(180);
    drain();

    // extremes: inverted speeds, full gains
    load_regs(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0, 16'h3FF);
    random_lines(150);
    drain();
    load_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0, 16'h7FFF, 16'h0);
    random_lines(150);
    drain();
    // speeds landing in the gain blend window
    load_regs(16'h0100, 16'h1E00, 16'h0C00, 16'h0200, 16'd1600, 16'd600, 16'd45);
    no_gaps = 1'b1;
    random_lines(150);
    no_gaps = 1'b0;
    random_lines(50);
    drain();
    load_regs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    random_lines(100);
    drain();

    for (int p = 0; p < 4; p++) begin
      load_regs(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                16'($urandom_range(0, 1023)));
      random_lines(75);
      // in the second pass the sender holds off until the pipe is empty
      if (p == 1) drain();
      random_lines(75);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d lines (%0d degenerate), %0d words checked over 9 register settings",
             sb.lines_taken, sb.degenerate_lines, sb.cmds_checked);
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.errors, sb.pending_cmds.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lkl_pkg.sv
hdl/lkl_line_if.sv
hdl/lkl_cmd_if.sv
hdl/lkl_cfg_if.sv
hdl/lkl_cordic.sv
hdl/lkl_dist.sv
hdl/lane_keeping_steering_law_top.sv
tb/tb_top.sv
